@@ src/rbc_pkg.sv @@
// Shared types, constants and byte functions for the block cipher unit.
// No dependencies; used by every module in src.
package rbc_pkg;

	localparam int MAX_COLUMNS = 8;
	localparam int MAX_ROUNDS = 14;
	localparam int KEY_DEPTH = MAX_COLUMNS * (MAX_ROUNDS + 1);
	localparam int KEY_AW = $clog2(KEY_DEPTH);
	localparam int RND_W = $clog2(MAX_ROUNDS + 1);
	localparam int COL_W = $clog2(MAX_COLUMNS + 1);

	localparam logic [2:0] CFG_KEY3 = 3'd3;
	localparam logic [2:0] CFG_KSIZE = 3'd4;
	localparam logic [2:0] CFG_BSIZE = 3'd5;

	localparam logic FUNC_ENC = 1'b0;

	typedef logic [7:0] byte_t;
	typedef logic [MAX_COLUMNS*32-1:0] state_t;

	// Round operation request from the sequencer to the round unit.
	typedef struct packed {
		logic load;
		logic inverse;
		logic key_only;
		logic last;
		logic [COL_W-1:0] nb;
	} round_ctl_t;

	function automatic byte_t xtime(input byte_t a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic byte_t sbox(input byte_t a);
		byte_t t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[a];
	endfunction

	function automatic byte_t inv_sbox(input byte_t a);
		byte_t t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		inv_sbox = t[a];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	// Columns for a size code; code three is taken as 256 bits.
	function automatic logic [COL_W-1:0] words_of(input logic [1:0] code);
		case (code)
			2'd0: words_of = COL_W'(4);
			2'd1: words_of = COL_W'(6);
			default: words_of = COL_W'(8);
		endcase
	endfunction

endpackage

@@ src/rijndael_block_cipher_unit.sv @@
// Top level of the Rijndael block cipher unit: registers, sequencer, result.
// Depends on rbc_pkg, rbc_key_sched and rbc_round.
//
// The unit encrypts or decrypts one block of 128, 192 or 256 bits under a
// key of 128, 192 or 256 bits, chosen by beats on the configuration port.
// After a configuration beat that writes a key word, the key size or the
// block size, the key schedule is re-expanded on the next input beat, one
// schedule word per cycle, before that block's rounds begin; the schedule is
// then kept. For each round the round key is gathered from the schedule
// memory one word a cycle, through a registered read, and the round unit
// then computes the whole round combinationally into its state register.
// After Nr+1 key additions the result is posted to the output register. The
// input is not ready while a block is in flight, nor while a configuration
// beat is offered. The result sits in an output register that parts the two
// sides: a new block may be taken while a result waits, and a finished block
// only holds back if the previous result has still not been taken.
module rijndael_block_cipher_unit (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic func,
	input logic [63:0] block_word_0,
	input logic [63:0] block_word_1,
	input logic [63:0] block_word_2,
	input logic [63:0] block_word_3,
	output logic out_valid,
	input logic out_ready,
	output logic [63:0] result_word_0,
	output logic [63:0] result_word_1,
	output logic [63:0] result_word_2,
	output logic [63:0] result_word_3
);
	import rbc_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCHED = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [255:0] key_q;
	logic [1:0] ksize_q, bsize_q;
	logic keys_ready_q;
	logic func_q;
	state_t blk_q, rkey_q, round_state, mask;
	logic [RND_W-1:0] step_q;
	logic [COL_W-1:0] col_q, nb;
	logic [3:0] nr;
	logic [KEY_AW-1:0] total, rd_addr;
	logic [31:0] rd_data;
	logic sched_busy, sched_start, rd_pending_q;
	logic out_valid_q;
	state_t res_q;
	round_ctl_t ctl;
	logic round_en;
	logic in_fire, cfg_fire, done_fire;

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign in_fire = in_valid && in_ready;
	// A finished block moves to the output register once that register is free.
	assign done_fire = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign nb = words_of(bsize_q);
	always_comb begin
		logic [COL_W-1:0] nk, m;
		nk = words_of(ksize_q);
		m = (nk > nb) ? nk : nb;
		nr = 4'(m + COL_W'(6));
	end
	assign total = KEY_AW'(nb) * (KEY_AW'(nr) + KEY_AW'(1));

	// Round index in schedule order: encrypt walks upward, decrypt downward.
	always_comb begin
		logic [RND_W-1:0] r;
		r = func_q ? RND_W'(nr - 4'(step_q)) : step_q;
		rd_addr = KEY_AW'(KEY_AW'(r) * KEY_AW'(nb) + KEY_AW'(col_q));
		for (int c = 0; c < MAX_COLUMNS; c++)
			mask[255-32*c -: 32] = (c < int'(nb)) ? 32'hffffffff : 32'h0;
	end

	assign sched_start = (state_q == ST_IDLE) && in_fire && !keys_ready_q;

	rbc_key_sched u_sched (
		.clk(clk), .arst_n(arst_n), .start(sched_start), .key(key_q),
		.key_size(ksize_q), .total(total), .busy(sched_busy),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	always_comb begin
		ctl.load = (step_q == '0);
		ctl.inverse = func_q;
		ctl.key_only = 1'b0;
		ctl.last = (4'(step_q) == nr);
		ctl.nb = nb;
	end
	assign round_en = (state_q == ST_ROUND);

	rbc_round u_round (
		.clk(clk), .en(round_en), .ctl(ctl), .load_data(blk_q & mask),
		.rkey(rkey_q), .state(round_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_q <= '0;
			ksize_q <= '0;
			bsize_q <= '0;
			keys_ready_q <= 1'b0;
			out_valid_q <= 1'b0;
			step_q <= '0;
			col_q <= '0;
			rd_pending_q <= 1'b0;
		end else begin
			if (done_fire)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (cfg_fire && cfg_index <= CFG_BSIZE) begin
				keys_ready_q <= 1'b0;
				if (cfg_index <= CFG_KEY3)
					key_q[255 - 64*cfg_index[1:0] -: 64] <= cfg_data;
				else if (cfg_index == CFG_KSIZE)
					ksize_q <= cfg_data[1:0];
				else
					bsize_q <= cfg_data[1:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						step_q <= '0;
						col_q <= '0;
						rd_pending_q <= 1'b0;
						state_q <= keys_ready_q ? ST_FETCH : ST_SCHED;
					end
				end
				ST_SCHED: begin
					if (!sched_busy) begin
						keys_ready_q <= 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					// One schedule word read per cycle, with the read data registered.
					rd_pending_q <= (col_q < nb);
					if (col_q < nb)
						col_q <= col_q + COL_W'(1);
					if (rd_pending_q && col_q == nb)
						state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					col_q <= '0;
					rd_pending_q <= 1'b0;
					if (4'(step_q) == nr) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + RND_W'(1);
						state_q <= ST_FETCH;
					end
				end
				ST_DONE: begin
					if (done_fire)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q <= func;
			blk_q <= {block_word_0, block_word_1, block_word_2, block_word_3};
		end
		if (state_q == ST_FETCH && rd_pending_q)
			rkey_q[255 - 32*(int'(col_q) - 1) -: 32] <= rd_data;
		if (state_q == ST_FETCH && col_q == '0)
			rkey_q <= '0;
		if (done_fire)
			res_q <= round_state & mask;
	end

	assign out_valid = out_valid_q;
	assign result_word_0 = res_q[255:192];
	assign result_word_1 = res_q[191:128];
	assign result_word_2 = res_q[127:64];
	assign result_word_3 = res_q[63:0];

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("input taken while busy");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid) else $error("result not raised");
	a_sched_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> !sched_busy) else $error("round during expansion");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (4'(step_q) <= nr)) else $error("round overrun");

endmodule

@@ src/rbc_key_sched.sv @@
// Key schedule expander and round key store for the block cipher unit.
// Depends on rbc_pkg.
module rbc_key_sched (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [255:0] key,
	input logic [1:0] key_size,
	input logic [rbc_pkg::KEY_AW-1:0] total,
	output logic busy,
	input logic [rbc_pkg::KEY_AW-1:0] rd_addr,
	output logic [31:0] rd_data
);
	import rbc_pkg::*;

	logic [31:0] mem [KEY_DEPTH];
	logic [31:0] hist_q [8];
	logic [KEY_AW-1:0] idx_q;
	logic [KEY_AW-1:0] total_q;
	logic [3:0] nk_q;
	logic [2:0] phase_q;
	logic [7:0] rc_q;
	logic busy_q;
	logic [31:0] t_rot, t_new, w_new;
	logic [3:0] nk_in;

	assign nk_in = 4'(words_of(key_size));
	assign busy = busy_q;

	always_comb begin
		t_rot = hist_q[0];
		if (phase_q == 3'd0)
			t_rot = sub_word({hist_q[0][23:0], hist_q[0][31:24]}) ^ {rc_q, 24'h0};
		else if (nk_q == 4'd8 && phase_q == 3'd4)
			t_rot = sub_word(hist_q[0]);
		t_new = t_rot;
		w_new = hist_q[nk_q[2:0] - 3'd1] ^ t_new;
	end

	// hist_q[0] is the newest word; hist_q[nk-1] is word i-nk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			phase_q <= '0;
			rc_q <= 8'h01;
			nk_q <= 4'd4;
			total_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q <= KEY_AW'(0);
			phase_q <= '0;
			rc_q <= 8'h01;
			nk_q <= nk_in;
			total_q <= total;
		end else if (busy_q) begin
			idx_q <= idx_q + KEY_AW'(1);
			if (idx_q >= KEY_AW'(nk_q)) begin
				phase_q <= (phase_q == 3'(nk_q - 4'd1)) ? 3'd0 : phase_q + 3'd1;
				if (phase_q == 3'd0)
					rc_q <= xtime(rc_q);
			end
			if (idx_q + KEY_AW'(1) == total_q)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !start) begin
			for (int k = 7; k > 0; k--)
				hist_q[k] <= hist_q[k-1];
			if (idx_q < KEY_AW'(nk_q))
				hist_q[0] <= key[255 - 32*idx_q[2:0] -: 32];
			else
				hist_q[0] <= w_new;
			mem[idx_q] <= (idx_q < KEY_AW'(nk_q)) ? key[255 - 32*idx_q[2:0] -: 32] : w_new;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ src/rbc_round.sv @@
// One Rijndael round (or a bare key addition) on the whole state per cycle while en is high, forward or inverse.
// Depends on rbc_pkg.
module rbc_round (
	input logic clk,
	input logic en,
	input rbc_pkg::round_ctl_t ctl,
	input rbc_pkg::state_t load_data,
	input rbc_pkg::state_t rkey,
	output rbc_pkg::state_t state
);
	import rbc_pkg::*;

	state_t st_q;
	state_t sb, sr, mc, nxt;

	assign state = st_q;

	function automatic byte_t gm(input byte_t a, input logic [3:0] m);
		byte_t a2, a4, a8;
		a2 = xtime(a);
		a4 = xtime(a2);
		a8 = xtime(a4);
		gm = (m[0] ? a : 8'h0) ^ (m[1] ? a2 : 8'h0) ^ (m[2] ? a4 : 8'h0) ^ (m[3] ? a8 : 8'h0);
	endfunction

	always_comb begin
		logic [2:0] s;
		logic [COL_W-1:0] src;
		byte_t c0, c1, c2, c3;
		for (int i = 0; i < 4*MAX_COLUMNS; i++)
			sb[255-8*i -: 8] = ctl.inverse ? inv_sbox(st_q[255-8*i -: 8])
				: sbox(st_q[255-8*i -: 8]);
		sr = '0;
		src = '0;
		for (int j = 0; j < 4; j++) begin
			s = (ctl.nb == COL_W'(8) && j > 1) ? 3'(j + 1) : 3'(j);
			for (int c = 0; c < MAX_COLUMNS; c++) begin
				if (c < int'(ctl.nb)) begin
					// The source column wraps at most once, so one subtraction is enough.
					if (ctl.inverse)
						src = COL_W'(c) + ctl.nb - COL_W'(s);
					else
						src = COL_W'(c) + COL_W'(s);
					if (src >= ctl.nb)
						src = src - ctl.nb;
					sr[255-8*(4*c+j) -: 8] = sb[255-8*(4*int'(src[2:0])+j) -: 8];
				end
			end
		end
		for (int c = 0; c < MAX_COLUMNS; c++) begin
			c0 = sr[255-32*c -: 8];
			c1 = sr[247-32*c -: 8];
			c2 = sr[239-32*c -: 8];
			c3 = sr[231-32*c -: 8];
			if (ctl.inverse) begin
				mc[255-32*c -: 32] = {
					gm(c0,4'he)^gm(c1,4'hb)^gm(c2,4'hd)^gm(c3,4'h9),
					gm(c0,4'h9)^gm(c1,4'he)^gm(c2,4'hb)^gm(c3,4'hd),
					gm(c0,4'hd)^gm(c1,4'h9)^gm(c2,4'he)^gm(c3,4'hb),
					gm(c0,4'hb)^gm(c1,4'hd)^gm(c2,4'h9)^gm(c3,4'he)};
			end else begin
				mc[255-32*c -: 32] = {
					gm(c0,4'h2)^gm(c1,4'h3)^c2^c3,
					c0^gm(c1,4'h2)^gm(c2,4'h3)^c3,
					c0^c1^gm(c2,4'h2)^gm(c3,4'h3),
					gm(c0,4'h3)^c1^c2^gm(c3,4'h2)};
			end
		end
		// Inverse rounds are computed as inverse sub, inverse shift, key, inverse
		// mix; the sequencer therefore hands the round keys in descending order.
		if (ctl.load)
			nxt = load_data ^ rkey;
		else if (ctl.key_only)
			nxt = st_q ^ rkey;
		else if (ctl.inverse)
			nxt = ctl.last ? (sr ^ rkey) : 'x;
		else
			nxt = (ctl.last ? sr : mc) ^ rkey;
		if (!ctl.load && !ctl.key_only && ctl.inverse && !ctl.last) begin
			// inverse: sub/shift of previous step then key then inverse mix
			nxt = sr ^ rkey;
			for (int c = 0; c < MAX_COLUMNS; c++) begin
				c0 = nxt[255-32*c -: 8];
				c1 = nxt[247-32*c -: 8];
				c2 = nxt[239-32*c -: 8];
				c3 = nxt[231-32*c -: 8];
				nxt[255-32*c -: 32] = {
					gm(c0,4'he)^gm(c1,4'hb)^gm(c2,4'hd)^gm(c3,4'h9),
					gm(c0,4'h9)^gm(c1,4'he)^gm(c2,4'hb)^gm(c3,4'hd),
					gm(c0,4'hd)^gm(c1,4'h9)^gm(c2,4'he)^gm(c3,4'hb),
					gm(c0,4'hb)^gm(c1,4'hd)^gm(c2,4'h9)^gm(c3,4'he)};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			st_q <= nxt;
	end

endmodule
